// ===== rtl/tvs_pkg.sv =====
`default_nettype none
package tvs_pkg;

    localparam int CFG_INDEX_BITS = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int COUNT_BITS     = 13;
    localparam int COORD_BITS     = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_X      = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Y      = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Z      = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_SPACING_X = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_SPACING_Y = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_SPACING_Z = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNT_X       = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNT_Y       = 4'd7;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] origin_x;
        logic [COORD_BITS-1:0] origin_y;
        logic [COORD_BITS-1:0] origin_z;
        logic [COORD_BITS-1:0] inv_x;
        logic [COORD_BITS-1:0] inv_y;
        logic [COORD_BITS-1:0] inv_z;
        logic [COUNT_BITS-1:0] count_x;
        logic [COUNT_BITS-1:0] count_y;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/tvs_ram.sv =====
`default_nettype none
module tvs_ram #(
    parameter int WIDTH      = 32,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic                  we,
    input  wire logic [DEPTH_BITS-1:0] addr,
    input  wire logic [WIDTH-1:0]      wdata,
    output logic      [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [2**DEPTH_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tvs_fifo.sv =====
`default_nettype none
module tvs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic      [WIDTH-1:0] pop_data
);
    localparam int PB = $clog2(DEPTH);
    localparam int CB = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PB-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CB-1:0]    count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CB'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + CB'(1);
        if (!push && pop) count_next = count_reg - CB'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= (wr_ptr_reg == PB'(DEPTH - 1)) ? '0 : wr_ptr_reg + PB'(1);
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == PB'(DEPTH - 1)) ? '0 : rd_ptr_reg + PB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_data;
    end
endmodule
`default_nettype wire

// ===== rtl/tvs_front.sv =====
`default_nettype none
module tvs_front
    import tvs_pkg::*;
#(
    parameter int GRID_ADDR_BITS = 16,
    parameter int SAMPLE_BITS    = 32
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cfg_t                      cfg,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [151:0]              s_tdata,
    input  wire logic                      s_tuser,
    output logic                           f_valid,
    input  wire logic                      f_ready,
    output logic                           f_kind,
    output logic      [GRID_ADDR_BITS-1:0] f_addr,
    output logic      [SAMPLE_BITS-1:0]    f_sample,
    output logic      [3*COORD_BITS-1:0]   f_mag,
    output logic      [2:0]                f_neg
);
    logic                      valid_reg;
    logic                      kind_reg;
    logic [GRID_ADDR_BITS-1:0] addr_reg;
    logic [SAMPLE_BITS-1:0]    sample_reg;
    logic [3*COORD_BITS-1:0]   mag_reg, mag_next;
    logic [2:0]                neg_reg, neg_next;

    logic [COORD_BITS-1:0] pos [3];
    logic [COORD_BITS-1:0] org [3];
    logic [COORD_BITS-1:0] inv [3];
    logic signed [COORD_BITS:0] diff [3];

    assign pos[0] = s_tdata[79:48];
    assign pos[1] = s_tdata[111:80];
    assign pos[2] = s_tdata[143:112];
    assign org[0] = cfg.origin_x;
    assign org[1] = cfg.origin_y;
    assign org[2] = cfg.origin_z;
    assign inv[0] = cfg.inv_x;
    assign inv[1] = cfg.inv_y;
    assign inv[2] = cfg.inv_z;

    // |pos - origin| always fits 32 bits; a negative difference is out of
    // range unless the scaled product is zero, i.e. unless inv is zero
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = $signed({pos[i][COORD_BITS-1], pos[i]})
                    - $signed({org[i][COORD_BITS-1], org[i]});
            mag_next[i*COORD_BITS +: COORD_BITS] = diff[i][COORD_BITS]
                ? COORD_BITS'(-diff[i]) : diff[i][COORD_BITS-1:0];
            neg_next[i] = diff[i][COORD_BITS] && (inv[i] != '0);
        end
    end

    assign s_tready = !valid_reg || f_ready;
    assign f_valid  = valid_reg;
    assign f_kind   = kind_reg;
    assign f_addr   = addr_reg;
    assign f_sample = sample_reg;
    assign f_mag    = mag_reg;
    assign f_neg    = neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            kind_reg   <= s_tuser;
            addr_reg   <= GRID_ADDR_BITS'(s_tdata[15:0]);
            sample_reg <= SAMPLE_BITS'(s_tdata[47:16]);
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tvs_back.sv =====
`default_nettype none
module tvs_back
    import tvs_pkg::*;
#(
    parameter int GRID_ADDR_BITS = 16,
    parameter int SAMPLE_BITS    = 32,
    parameter int FRAC_BITS      = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire logic [1+GRID_ADDR_BITS+SAMPLE_BITS+3*COORD_BITS+3-1:0] q_data,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [95:0]       m_tdata,
    output logic                   m_tuser
);
    localparam int GAB  = GRID_ADDR_BITS;
    localparam int S    = SAMPLE_BITS;
    localparam int F    = FRAC_BITS;
    localparam int PLB  = 2 * COUNT_BITS;
    localparam int BW   = GAB + PLB + 1;
    localparam int RW   = S + F + 2;
    localparam int YW   = RW + F + 2;
    localparam int OFF_ADDR = 1;
    localparam int OFF_SAMP = 1 + GAB;
    localparam int OFF_MAG  = 1 + GAB + S;
    localparam int OFF_NEG  = OFF_MAG + 3 * COORD_BITS;
    localparam int NST  = 11;
    localparam logic signed [YW:0] HALF_Y = (YW + 1)'(1) <<< (F - 1);
    localparam logic signed [YW:0] HALF_X = (YW + 1)'(1) <<< (2 * F - 1);
    localparam logic signed [F+1:0] ONE_W = (F + 2)'(1) <<< F;

    logic en;
    logic [NST-1:0] v_reg;
    logic [PLB-1:0] plane_reg;

    // carried fields
    logic [NST-1:0] kind_reg;
    logic [GAB-1:0] waddr_reg [4];
    logic [S-1:0]   wdata_reg [4];
    logic [F-1:0]   frac_reg [1:8][3];
    logic           ok_reg [1:NST-1];

    // stage 0: scale
    logic [2*COORD_BITS-1:0] prod0_reg [3];
    logic [2:0]              neg0_reg;
    // stage 1: cell checks
    logic [COUNT_BITS-1:0]   cx1_reg, cy1_reg;
    logic [GAB-1:0]          cz1_reg;
    // stage 2: strides
    logic [COUNT_BITS-1:0]   cx2_reg;
    logic [PLB-1:0]          cyp2_reg;
    logic [GAB+PLB-1:0]      czp2_reg;
    // stage 3: base address
    logic [GAB-1:0]          base3_reg;
    // blend
    logic signed [RW-1:0]    zp5_reg [8];
    logic signed [RW-1:0]    row6_reg [4];
    logic signed [YW-1:0]    yp7_reg [4];
    logic signed [RW-1:0]    line8_reg [2];
    logic signed [YW-1:0]    xp9_reg [2];
    logic signed [S-1:0]     res10_reg;

    logic [S-1:0]            rdata [8];
    logic [GAB-1:0]          ram_addr [8];
    logic                    ram_we;

    // output and statistics
    logic                    m_valid_reg;
    logic [31:0]             value_reg, min_reg, max_reg, min_next, max_next;
    logic                    oor_reg;
    logic                    any_seen_reg, any_seen_next;

    assign en      = !m_valid_reg || m_tready;
    assign q_ready = en;

    always_ff @(posedge aclk) begin
        plane_reg <= cfg.count_x * cfg.count_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-2:0], q_valid};
        end
    end

    // front-end checks combinational in stage 1
    logic [COORD_BITS-1:0] cell_idx [3];
    logic                  ok1_next;
    always_comb begin
        for (int i = 0; i < 3; i++) cell_idx[i] = prod0_reg[i][2*COORD_BITS-1:COORD_BITS];
        ok1_next = (neg0_reg == '0)
            && ({1'b0, cell_idx[0]} + 33'd1 < {20'd0, cfg.count_x})
            && ({1'b0, cell_idx[1]} + 33'd1 < {20'd0, cfg.count_y})
            && (cell_idx[2][COORD_BITS-1:GAB] == '0);
    end

    // highest corner is base + 1 + row stride + plane stride
    logic [BW-1:0] base3_next, top3_next;
    always_comb begin
        base3_next = BW'(cx2_reg) + BW'(cyp2_reg) + BW'(czp2_reg);
        top3_next  = base3_next + BW'(1) + BW'(cfg.count_x) + BW'(plane_reg);
    end

    logic signed [F+1:0] w0 [3], w1 [3];
    logic signed [YW:0]  ysum [2];
    logic signed [YW:0]  xsum;
    always_comb begin
        w0[2] = ONE_W - $signed({2'b0, frac_reg[4][2]});
        w1[2] = $signed({2'b0, frac_reg[4][2]});
        w0[1] = ONE_W - $signed({2'b0, frac_reg[6][1]});
        w1[1] = $signed({2'b0, frac_reg[6][1]});
        w0[0] = ONE_W - $signed({2'b0, frac_reg[8][0]});
        w1[0] = $signed({2'b0, frac_reg[8][0]});
        for (int a = 0; a < 2; a++) begin
            ysum[a] = (YW + 1)'(yp7_reg[a]) + (YW + 1)'(yp7_reg[a+2]) + HALF_Y;
        end
        xsum = (YW + 1)'(xp9_reg[0]) + (YW + 1)'(xp9_reg[1]) + HALF_X;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod0_reg[i] <= q_data[OFF_MAG + i*COORD_BITS +: COORD_BITS]
                              * (i == 0 ? cfg.inv_x : (i == 1 ? cfg.inv_y : cfg.inv_z));
            end
            neg0_reg     <= q_data[OFF_NEG +: 3];
            kind_reg     <= {kind_reg[NST-2:0], q_data[0]};
            waddr_reg[0] <= q_data[OFF_ADDR +: GAB];
            wdata_reg[0] <= q_data[OFF_SAMP +: S];
            for (int k = 1; k < 4; k++) begin
                waddr_reg[k] <= waddr_reg[k-1];
                wdata_reg[k] <= wdata_reg[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                frac_reg[1][i] <= prod0_reg[i][COORD_BITS-1 -: F];
            end
            for (int s = 2; s <= 8; s++) frac_reg[s] <= frac_reg[s-1];
            ok_reg[1] <= ok1_next;
            ok_reg[2] <= ok_reg[1];
            ok_reg[3] <= ok_reg[2] && (top3_next[BW-1:GAB] == '0);
            for (int s = 4; s < NST; s++) ok_reg[s] <= ok_reg[s-1];
            cx1_reg  <= cell_idx[0][COUNT_BITS-1:0];
            cy1_reg  <= cell_idx[1][COUNT_BITS-1:0];
            cz1_reg  <= cell_idx[2][GAB-1:0];
            cx2_reg  <= cx1_reg;
            cyp2_reg <= cy1_reg * cfg.count_x;
            czp2_reg <= cz1_reg * plane_reg;
            base3_reg <= base3_next[GAB-1:0];
            for (int k = 0; k < 8; k++) begin
                zp5_reg[k] <= RW'($signed(rdata[k])) * RW'(k < 4 ? w0[2] : w1[2]);
            end
            for (int j = 0; j < 4; j++) row6_reg[j] <= zp5_reg[j] + zp5_reg[j+4];
            for (int k = 0; k < 4; k++) begin
                yp7_reg[k] <= YW'(row6_reg[k]) * YW'(k < 2 ? w0[1] : w1[1]);
            end
            for (int a = 0; a < 2; a++) line8_reg[a] <= ysum[a][F +: RW];
            xp9_reg[0] <= YW'(line8_reg[0]) * YW'(w0[0]);
            xp9_reg[1] <= YW'(line8_reg[1]) * YW'(w1[0]);
            res10_reg  <= xsum[2*F +: S];
        end
    end

    // corner banks, one full copy of the grid each; writes go to all
    assign ram_we = v_reg[3] && (kind_reg[3] == KIND_WRITE) && en;
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            ram_addr[k] = base3_reg + GAB'(k & 1)
                + ((k & 2) != 0 ? GAB'(cfg.count_x) : '0)
                + ((k & 4) != 0 ? GAB'(plane_reg) : '0);
            if (kind_reg[3] == KIND_WRITE) ram_addr[k] = waddr_reg[3];
        end
    end

    for (genvar k = 0; k < 8; k++) begin : g_bank
        tvs_ram #(.WIDTH(S), .DEPTH_BITS(GAB)) u_ram (
            .aclk  (aclk),
            .en    (en),
            .we    (ram_we),
            .addr  (ram_addr[k]),
            .wdata (wdata_reg[3]),
            .rdata (rdata[k])
        );
    end

    // running statistics
    logic        last_valid, last_ok;
    logic [31:0] r32;
    assign last_valid = v_reg[NST-1] && (kind_reg[NST-1] == KIND_POINT);
    assign last_ok    = ok_reg[NST-1];
    assign r32        = 32'($signed(res10_reg));

    always_comb begin
        min_next      = min_reg;
        max_next      = max_reg;
        any_seen_next = any_seen_reg;
        if (last_valid && last_ok) begin
            any_seen_next = 1'b1;
            if (!any_seen_reg) begin
                min_next = r32;
                max_next = r32;
            end else begin
                if ($signed(r32) < $signed(min_reg)) min_next = r32;
                if ($signed(r32) > $signed(max_reg)) max_next = r32;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            min_reg      <= '0;
            max_reg      <= '0;
            any_seen_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg  <= last_valid;
            min_reg      <= min_next;
            max_reg      <= max_next;
            any_seen_reg <= any_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= last_ok ? r32 : '0;
            oor_reg   <= !last_ok;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {max_reg, min_reg, value_reg};
    assign m_tuser  = oor_reg;

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && oor_reg |-> value_reg == '0)
        else $error("out-of-range result with nonzero value");
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $signed(min_reg) <= $signed(max_reg))
        else $error("running minimum above maximum");
    a_unseen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !any_seen_reg |-> min_reg == '0 && max_reg == '0)
        else $error("statistics moved before any in-range point");
endmodule
`default_nettype wire

// ===== rtl/trilinear_volume_sampler_top.sv =====
// Trilinear volume sampler.
// Input stream (s_*): one transaction per item. s_tuser is the kind:
// 0 stores s_tdata sample_value at sample_address, 1 samples the grid at
// (pos_x, pos_y, pos_z). Only point items produce a result transaction.
// Result stream (m_*): interpolated value, running min and max in m_tdata,
// out_of_range in m_tuser (value is then zero and the statistics hold).
// Config channel (cfg_*): index plus data, always ready; write only while idle.
// Throughput: one item per clock while m_tready is high, set by the eight
// corner banks, each a full copy of the grid, so all corners read in parallel.
// Path to m_tvalid: the input register loads at the accepting edge, then one
// queue slot, eleven back-end stages and the output register.
// A write reaches the grid four back-end stages after leaving the queue; later
// points are issued behind it in order, so they always see it.
// Reset: control and statistics clear, configuration goes to origin 0,
// inverse spacing 65536, counts 2; grid contents undefined until written.
// Receiver stall: the back end freezes in place, the queue fills, then
// s_tready drops.
`default_nettype none
module trilinear_volume_sampler_top
    import tvs_pkg::*;
#(
    parameter int GRID_ADDR_BITS = 16,
    parameter int SAMPLE_BITS    = 32,
    parameter int FRAC_BITS      = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // sample_address[15:0], sample_value[47:16], pos_x[79:48], pos_y[111:80],
    // pos_z[143:112], zero pad
    input  wire logic [151:0]              s_tdata,
    // kind
    input  wire logic                      s_tuser,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // value[31:0], running_min[63:32], running_max[95:64]
    output logic      [95:0]               m_tdata,
    // out_of_range
    output logic                           m_tuser,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [31:0]               cfg_data
);
    localparam int QW = 1 + GRID_ADDR_BITS + SAMPLE_BITS + 3 * COORD_BITS + 3;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    // register file; unlisted indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.origin_z <= '0;
            cfg_reg.inv_x    <= 32'd65536;
            cfg_reg.inv_y    <= 32'd65536;
            cfg_reg.inv_z    <= 32'd65536;
            cfg_reg.count_x  <= 13'd2;
            cfg_reg.count_y  <= 13'd2;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ORIGIN_X:      cfg_reg.origin_x <= cfg_data;
                CFG_ORIGIN_Y:      cfg_reg.origin_y <= cfg_data;
                CFG_ORIGIN_Z:      cfg_reg.origin_z <= cfg_data;
                CFG_INV_SPACING_X: cfg_reg.inv_x    <= cfg_data;
                CFG_INV_SPACING_Y: cfg_reg.inv_y    <= cfg_data;
                CFG_INV_SPACING_Z: cfg_reg.inv_z    <= cfg_data;
                CFG_COUNT_X:       cfg_reg.count_x  <= cfg_data[COUNT_BITS-1:0];
                CFG_COUNT_Y:       cfg_reg.count_y  <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic                      f_valid, f_ready, f_kind;
    logic [GRID_ADDR_BITS-1:0] f_addr;
    logic [SAMPLE_BITS-1:0]    f_sample;
    logic [3*COORD_BITS-1:0]   f_mag;
    logic [2:0]                f_neg;
    logic                      q_valid, q_ready;
    logic [QW-1:0]             q_data;

    tvs_front #(
        .GRID_ADDR_BITS (GRID_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_kind   (f_kind),
        .f_addr   (f_addr),
        .f_sample (f_sample),
        .f_mag    (f_mag),
        .f_neg    (f_neg)
    );

    tvs_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_neg, f_mag, f_sample, f_addr, f_kind}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    tvs_back #(
        .GRID_ADDR_BITS (GRID_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .FRAC_BITS      (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule
`default_nettype wire

// ===== tb/tb_trilinear_volume_sampler_top.sv =====
`timescale 1ns / 1ps
module tb_trilinear_volume_sampler_top;
    import tvs_pkg::*;

    localparam int    GRID_WORDS  = 65536;
    localparam int    SETTLE_CYC  = 24;    // extra wait once no results are owed
    localparam int    HANG_LIMIT  = 4000;  // cycles with no transaction at all
    localparam int    HOLD_CYC    = 300;   // long receiver hold-off
    localparam longint ONE_Q      = 64'sd65536;

    // -------------------------------------------------------------------------
    // Scoreboard: mirror of grid, registers and running statistics, plus the
    // queue of results still owed by the block.
    // -------------------------------------------------------------------------
    class sampler_scoreboard;
        typedef struct packed {
            bit [31:0] value;
            bit        oor;
            bit [31:0] lo;
            bit [31:0] hi;
        } sample_result_t;

        bit [31:0]      origin [3];
        bit [31:0]      inv    [3];
        bit [12:0]      cnt_x, cnt_y;
        bit [31:0]      grid [int];
        bit [31:0]      least_val, greatest_val;
        bit             seen_any;
        sample_result_t owed_q [$];
        int             errors, points, hits, writes, reg_writes;

        function new();
            for (int i = 0; i < 3; i++) begin
                origin[i] = 0;
                inv[i]    = 32'd65536;
            end
            cnt_x = 2;
            cnt_y = 2;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, bit [31:0] d);
            reg_writes++;
            case (idx)
                CFG_ORIGIN_X:      origin[0] = d;
                CFG_ORIGIN_Y:      origin[1] = d;
                CFG_ORIGIN_Z:      origin[2] = d;
                CFG_INV_SPACING_X: inv[0] = d;
                CFG_INV_SPACING_Y: inv[1] = d;
                CFG_INV_SPACING_Z: inv[2] = d;
                CFG_COUNT_X:       cnt_x = d[12:0];
                CFG_COUNT_Y:       cnt_y = d[12:0];
                default: ;
            endcase
        endfunction

        // grid units on one axis; returns 0 below the origin unless the product is 0
        function bit map_axis(bit [31:0] pos, bit [31:0] org, bit [31:0] sp,
                              output longint unsigned cell_idx, output longint frac);
            longint          diff;
            longint unsigned mag, prod;
            diff = longint'($signed(pos)) - longint'($signed(org));
            mag  = (diff < 0) ? longint'(-diff) : diff;
            prod = mag * longint'({32'h0, sp});
            cell_idx = prod >> 32;
            frac = longint'((prod >> 16) & 64'hFFFF);
            return !(diff < 0 && prod != 0);
        endfunction

        function bit locate(bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                            output longint unsigned base, output longint unsigned plane,
                            output longint fx, output longint fy, output longint fz);
            longint unsigned cx, cy, cz;
            bit ok;
            ok = map_axis(px, origin[0], inv[0], cx, fx);
            ok = map_axis(py, origin[1], inv[1], cy, fy) && ok;
            ok = map_axis(pz, origin[2], inv[2], cz, fz) && ok;
            if (ok && !(cx + 1 < cnt_x && cy + 1 < cnt_y))
                ok = 0;
            plane = longint'(cnt_x) * cnt_y;
            base  = cx + cy * cnt_x + cz * plane;
            if (ok && base + 1 + cnt_x + plane >= GRID_WORDS)
                ok = 0;
            return ok;
        endfunction

        // true when the point reads no grid entry that was never written
        function bit point_safe(bit [31:0] px, bit [31:0] py, bit [31:0] pz);
            longint unsigned base, plane;
            longint fx, fy, fz;
            if (!locate(px, py, pz, base, plane, fx, fy, fz))
                return 1;
            for (int a = 0; a < 2; a++)
                for (int b = 0; b < 2; b++)
                    for (int c = 0; c < 2; c++)
                        if (!grid.exists(int'(base + a + b * cnt_x + c * plane)))
                            return 0;
            return 1;
        endfunction

        function longint corner(longint unsigned a);
            bit [31:0] w;
            w = grid.exists(int'(a)) ? grid[int'(a)] : 32'h0;
            return longint'($signed(w));
        endfunction

        function longint round_shift(longint v, int sh);
            return (v + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        // cell for aimed points, with every corner inside memory
        function bit pick_cell(output int unsigned tx, output int unsigned ty,
                               output int unsigned tz, output longint unsigned base);
            longint plane, room;
            plane = longint'(cnt_x) * cnt_y;
            tx    = $urandom_range(0, cnt_x - 2);
            ty    = $urandom_range(0, cnt_y - 2);
            room  = GRID_WORDS - 2 - cnt_x - plane - (tx + ty * cnt_x);
            if (room < 0) begin
                tx   = 0;
                ty   = 0;
                room = GRID_WORDS - 2 - cnt_x - plane;
            end
            if (room < 0)
                return 0;
            tz   = $urandom_range(0, int'(room / plane));
            base = tx + ty * cnt_x + tz * plane;
            return 1;
        endfunction

        function void note_input(bit kind, bit [15:0] addr, bit [31:0] val,
                                 bit [31:0] px, bit [31:0] py, bit [31:0] pz);
            longint unsigned base, plane, ad;
            longint fx, fy, fz, acc;
            longint row [2];
            longint line [2];
            sample_result_t r;
            if (kind == KIND_WRITE) begin
                grid[int'(addr)] = val;
                writes++;
                return;
            end
            points++;
            r = '0;
            if (locate(px, py, pz, base, plane, fx, fy, fz)) begin
                for (int a = 0; a < 2; a++) begin
                    for (int b = 0; b < 2; b++) begin
                        ad     = base + a + b * cnt_x;
                        row[b] = corner(ad) * (ONE_Q - fz) + corner(ad + plane) * fz;
                    end
                    line[a] = round_shift(row[0] * (ONE_Q - fy) + row[1] * fy, 16);
                end
                acc     = round_shift(line[0] * (ONE_Q - fx) + line[1] * fx, 32);
                r.value = acc[31:0];
                hits++;
                if (!seen_any) begin
                    least_val    = r.value;
                    greatest_val = r.value;
                    seen_any     = 1;
                end else begin
                    if ($signed(r.value) < $signed(least_val))    least_val    = r.value;
                    if ($signed(r.value) > $signed(greatest_val)) greatest_val = r.value;
                end
            end else begin
                r.oor = 1;
            end
            r.lo = least_val;
            r.hi = greatest_val;
            owed_q.push_back(r);
        endfunction

        function void check_result(bit [95:0] d, bit oor);
            sample_result_t e, got;
            got = {d[31:0], oor, d[63:32], d[95:64]};
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with nothing pending: value=%h oor=%b",
                             d[31:0], oor);
                return;
            end
            e = owed_q.pop_front();
            if (got != e) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: exp value=%h oor=%b min=%h max=%h, ",
                              "got value=%h oor=%b min=%h max=%h"},
                             e.value, e.oor, e.lo, e.hi,
                             got.value, got.oor, got.lo, got.hi);
            end
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // Clock, reset and block
    // -------------------------------------------------------------------------
    bit aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [151:0]              s_tdata   = '0;  // addr, value, pos_x, pos_y, pos_z, pad
    logic                      s_tuser   = 1'b0; // kind
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [95:0]               m_tdata;          // value, running_min, running_max
    logic                      m_tuser;          // out_of_range
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [31:0]               cfg_data  = '0;

    trilinear_volume_sampler_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sampler_scoreboard sb = new();

    bit quiet;      // final part of the run: no idling on either side
    bit hold_req;   // asks the receiver for one long hold-off
    int settings_run;

    // -------------------------------------------------------------------------
    // Result side: random ready with stall bursts, one long hold-off on request.
    // Ready is sampled by the monitor before this edge's update lands.
    // -------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYC - 1;
                m_tready   <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 11);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // every result transaction is checked against the oldest pending one
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // watchdog: any transaction on any channel resets the idle count
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d results pending",
                     HANG_LIMIT, sb.owed_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // Input side
    // -------------------------------------------------------------------------
    // one input transaction; valid stays high between back-to-back items
    task automatic send_item(bit kind, bit [15:0] addr, bit [31:0] val,
                             bit [31:0] px, bit [31:0] py, bit [31:0] pz);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {8'h00, pz, py, px, val, addr};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, addr, val, px, py, pz);
    endtask

    task automatic write_sample(bit [15:0] addr, bit [31:0] val);
        send_item(KIND_WRITE, addr, val, $urandom, $urandom, $urandom);
    endtask

    task automatic query_point(bit [31:0] px, bit [31:0] py, bit [31:0] pz);
        send_item(KIND_POINT, 16'($urandom), $urandom, px, py, pz);
    endtask

    // block idle: input quiet, nothing owed, back end flushed
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic load_settings(bit [31:0] regs [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_INDEX_BITS'(i);
            cfg_data  <= regs[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(CFG_INDEX_BITS'(i), regs[i]);
        end
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    function automatic bit [31:0] sample_pick();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 255) << 8;  // byte sample in Q24.8
            default: return $urandom;
        endcase
    endfunction

    // position whose grid coordinate lands in cell t, random fraction
    function automatic bit [31:0] aim(bit [31:0] org, bit [31:0] sp, longint unsigned t);
        longint unsigned num, d;
        if (sp == 0)
            return org + $urandom_range(0, 32'hFFFF);
        num = (t << 32) + ($urandom >> 1);
        d   = (num + sp - 1) / sp;
        return org + d[31:0];
    endfunction

    function automatic bit [31:0] rand_origin();
        return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
    endfunction

    // noise point that reads nothing unwritten; gives up after some tries
    task automatic noise_point();
        bit [31:0] p [3];
        for (int k = 0; k < 20; k++) begin
            for (int i = 0; i < 3; i++)
                p[i] = $urandom_range(0, 1) ? $urandom
                                            : sb.origin[i] + $urandom_range(0, 32'h3F_FFFF) - 32'h8_0000;
            if (sb.point_safe(p[0], p[1], p[2])) begin
                query_point(p[0], p[1], p[2]);
                return;
            end
        end
        write_sample(16'($urandom), sample_pick());
    endtask

    // one setting: load registers, write a few full cells, then mixed traffic
    task automatic run_setting(bit [31:0] regs [8], int n_items, bit with_hold);
        int unsigned     cx [4], cy [4], cz [4];
        longint unsigned base;
        int              n_cells;
        bit [31:0]       p [3];
        int              sel;
        settle();
        load_settings(regs);
        n_cells = 0;
        for (int c = 0; c < 4; c++) begin
            if (sb.pick_cell(cx[n_cells], cy[n_cells], cz[n_cells], base)) begin
                for (int a = 0; a < 2; a++)
                    for (int b = 0; b < 2; b++)
                        for (int z = 0; z < 2; z++)
                            write_sample(16'(base + a + b * sb.cnt_x +
                                             z * longint'(sb.cnt_x) * sb.cnt_y),
                                         sample_pick());
                n_cells++;
            end
        end
        if (with_hold)
            hold_req = 1'b1;
        for (int n = 0; n < n_items; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                write_sample(16'($urandom), sample_pick());
            end else if (sel < 35 || n_cells == 0) begin
                noise_point();
            end else begin
                sel  = $urandom_range(0, n_cells - 1);
                p[0] = aim(sb.origin[0], sb.inv[0], cx[sel]);
                p[1] = aim(sb.origin[1], sb.inv[1], cy[sel]);
                p[2] = aim(sb.origin[2], sb.inv[2], cz[sel]);
                if (sb.point_safe(p[0], p[1], p[2]))
                    query_point(p[0], p[1], p[2]);
                else
                    noise_point();
            end
        end
    endtask

    function automatic void random_regs(output bit [31:0] r [8]);
        r = '{rand_origin(), rand_origin(), rand_origin(),
              $urandom_range(32'h4000, 32'h4_0000), $urandom_range(32'h4000, 32'h4_0000),
              $urandom_range(32'h4000, 32'h4_0000),
              $urandom_range(2, 40), $urandom_range(2, 40)};
    endfunction

    // -------------------------------------------------------------------------
    // Main sequence
    // -------------------------------------------------------------------------
    initial begin
        bit [31:0] regs [8];

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings: 2x2 rows, unit spacing, origin 0.
        // Fill z planes 0..2 so cells 0 and 1 along z are readable.
        write_sample(16'd0,  32'h7FFF_FFFF);
        write_sample(16'd1,  32'h8000_0000);
        write_sample(16'd2,  32'h0000_0000);
        write_sample(16'd3,  32'hFFFF_FFFF);
        for (int a = 4; a < 12; a++)
            write_sample(16'(a), sample_pick());
        write_sample(16'hFFFF, 32'h1234_5600);
        query_point(32'h0, 32'h0, 32'h0);                    // exact corner
        query_point(32'h8000, 32'h8000, 32'h8000);           // half-way blend
        query_point(32'hFFFF, 32'hFFFF, 32'h1_FFFF);         // largest fraction
        query_point(32'hFFFF_FFFF, 32'h0, 32'h0);            // negative coordinate
        query_point(32'h0, 32'h0, 32'h8000_0000);            // most negative
        query_point(32'h1_0000, 32'h0, 32'h0);               // cell beyond grid in x
        query_point(32'h0, 32'h1_0000, 32'h0);               // cell beyond grid in y
        query_point(32'h0, 32'h0, 32'h7FFF_0000);            // beyond memory via z
        query_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query_point(32'h4000, 32'hC000, 32'h1_2345);

        // settings sweep, extremes first
        regs = '{32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'd2, 32'd2};
        run_setting(regs, 40, 1'b0);
        regs = '{32'hFFFD_0000, 32'h0001_8000, 32'h0, 32'h8000, 32'h2_0000, 32'h1_0000,
                 32'd5, 32'd3};
        run_setting(regs, 50, 1'b0);
        regs = '{32'h8000_0000, 32'h7FFF_FFFF, rand_origin(), 32'h0, 32'hFFFF_FFFF,
                 32'h1_0000, 32'd4096, 32'd2};
        run_setting(regs, 50, 1'b0);
        random_regs(regs);
        run_setting(regs, 60, 1'b1);                         // receiver holds off here
        regs = '{32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000,
                 32'd4096, 32'd4096};                        // plane exceeds memory
        run_setting(regs, 30, 1'b0);
        regs = '{rand_origin(), rand_origin(), rand_origin(), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'd2, 32'd4096};
        run_setting(regs, 40, 1'b0);
        random_regs(regs);
        run_setting(regs, 60, 1'b0);
        random_regs(regs);
        run_setting(regs, 60, 1'b0);
        quiet = 1'b1;
        random_regs(regs);
        run_setting(regs, 60, 1'b0);

        settle();
        $display("Covered %0d points (%0d in range) and %0d grid writes",
                 sb.points, sb.hits, sb.writes);
        $display("over %0d register settings (%0d register writes), %0d mismatches",
                 settings_run, sb.reg_writes, sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tvs_pkg.sv
rtl/tvs_ram.sv
rtl/tvs_fifo.sv
rtl/tvs_front.sv
rtl/tvs_back.sv
rtl/trilinear_volume_sampler_top.sv
tb/tb_trilinear_volume_sampler_top.sv
